[design/bctc_pkg.sv]
// Shared types, constants and codes of the block cache tag controller.
`default_nettype none

package bctc_pkg;

    // Geometry of the cache and of the backing device.
    localparam int ENTRIES           = 16;
    localparam int SECTORS_PER_BLOCK = 2;
    localparam int ENTRY_W           = $clog2(ENTRIES);

    // Fixed field widths.
    localparam int TAG_W      = 32;
    localparam int SECTOR_W   = 33;
    localparam int OUT_IDX_W  = 4;
    localparam int STATUS_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SECTOR_W;

    // Width that holds (block + 1) * SECTORS_PER_BLOCK without overflow.
    localparam int PROD_W = TAG_W + 1 + $clog2(SECTORS_PER_BLOCK + 1);

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DEV_ERR = 2'd2;

    // Request operations.
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEV_SECTORS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_ATTACHED = 1'd1;

    typedef logic [TAG_W-1:0]                 tag_t;
    typedef logic [ENTRY_W-1:0]               entry_idx_t;
    typedef logic [ENTRIES-1:0]               valid_vec_t;
    typedef logic [ENTRIES-1:0][TAG_W-1:0]    tag_vec_t;

    // Outcome of the parallel tag search.
    typedef struct packed {
        logic       hit;
        entry_idx_t hit_idx;
        logic       free;
        entry_idx_t free_idx;
    } lookup_t;

    // State update requested for one request.
    typedef struct packed {
        logic       en;
        entry_idx_t idx;
        logic       set_valid;
        logic       adv_ptr;
    } update_t;

endpackage

`default_nettype wire

[design/bctc_lookup.sv]
// Parallel tag compare and lowest-free-entry search over all cache entries.
`default_nettype none

module bctc_lookup (
    input  wire bctc_pkg::valid_vec_t valid,
    input  wire bctc_pkg::tag_vec_t   tags,
    input  wire bctc_pkg::tag_t       blk,
    output bctc_pkg::lookup_t         result
);

    // Scan from the top so that the lowest matching or free entry wins.
    always_comb
    begin
        result = '0;
        for (int i = bctc_pkg::ENTRIES - 1; i >= 0; i--)
        begin
            if (valid[i] && (tags[i] == blk))
            begin
                result.hit     = 1'b1;
                result.hit_idx = bctc_pkg::ENTRY_W'(i);
            end
            if (!valid[i])
            begin
                result.free     = 1'b1;
                result.free_idx = bctc_pkg::ENTRY_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

[design/bctc_tag_store.sv]
// Valid bits, tags and round-robin victim pointer of the cache.
`default_nettype none

module bctc_tag_store (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       clear,
    input  wire bctc_pkg::update_t    upd,
    input  wire bctc_pkg::tag_t       blk,
    output bctc_pkg::valid_vec_t      valid,
    output bctc_pkg::tag_vec_t        tags,
    output bctc_pkg::entry_idx_t      ptr
);

    bctc_pkg::valid_vec_t valid_reg;
    bctc_pkg::valid_vec_t valid_next;
    bctc_pkg::entry_idx_t ptr_reg;
    bctc_pkg::entry_idx_t ptr_next;
    bctc_pkg::tag_vec_t   tags_reg;

    // Next valid bits and pointer; an attach clears both.
    always_comb
    begin
        valid_next = valid_reg;
        ptr_next   = ptr_reg;
        if (clear)
        begin
            valid_next = '0;
            ptr_next   = '0;
        end
        else if (upd.en)
        begin
            valid_next[upd.idx] = upd.set_valid;
            if (upd.adv_ptr)
            begin
                if (ptr_reg == bctc_pkg::ENTRY_W'(bctc_pkg::ENTRIES - 1))
                begin
                    ptr_next = '0;
                end
                else
                begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ptr_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            ptr_reg   <= ptr_next;
        end
    end

    // Tags are only meaningful while their valid bit is set.
    always_ff @(posedge clk)
    begin
        if (!clear && upd.en && upd.set_valid)
        begin
            tags_reg[upd.idx] <= blk;
        end
    end

    assign valid = valid_reg;
    assign tags  = tags_reg;
    assign ptr   = ptr_reg;

`ifndef SYNTHESIS
    // An attach leaves no entry valid and the pointer at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> (valid_reg == '0) && (ptr_reg == '0))
        else $error("tag store not cleared after attach");

    // The round-robin pointer is used only when every entry is valid.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!clear && upd.en && upd.adv_ptr) |-> (&valid_reg))
        else $error("victim pointer advanced with a free entry present");

    // The pointer always names an existing entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= bctc_pkg::ENTRY_W'(bctc_pkg::ENTRIES - 1))
        else $error("victim pointer out of range");
`endif

endmodule

`default_nettype wire

[design/block_cache_tag_controller_top.sv]
// Top level of the block cache tag controller: channels, decision logic, stage registers.
//
// Usage: requests enter on the input channel (func, block_number, device_ok) and
// each produces exactly one result beat (status, hit, entry_index, start_sector)
// on the output channel. A beat moves when valid is high and stall is low.
// The configuration channel writes the device size in sectors (index 0) and the
// attach flag (index 1); it is always ready and must only be used while the block
// is idle. Writing 1 to the attach flag empties the cache and resets the victim pointer.
// A request beat is accepted into the input register; the tag search, victim choice
// and state update run in one pass from the input register into the result register.
// Throughput: one request per cycle unless the receiver stalls, set by the combinational
// search over all tag registers and the update of the tag store in the same cycle.
// When the receiver stalls, the result register holds its beat; the input
// register still takes one more request, then in_stall rises until the
// result moves on.
// Reset empties the cache, clears the victim pointer and both configuration
// registers, and drops both valid signals.
`default_nettype none

module block_cache_tag_controller_top (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // Request channel
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire                                 func,
    input  wire  [bctc_pkg::TAG_W-1:0]          block_number,
    input  wire                                 device_ok,
    // Result channel
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [bctc_pkg::STATUS_W-1:0]       status,
    output logic                                hit,
    output logic [bctc_pkg::OUT_IDX_W-1:0]      entry_index,
    output logic [bctc_pkg::SECTOR_W-1:0]       start_sector,
    // Configuration channel
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [bctc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [bctc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    // Configuration registers.
    logic [bctc_pkg::SECTOR_W-1:0] dev_sectors_reg;
    logic                          attached_reg;
    logic                          cfg_we;
    logic                          attach_clear;

    // Input register.
    logic                          s1_valid_reg;
    logic                          s1_func_reg;
    bctc_pkg::tag_t                s1_blk_reg;
    logic                          s1_ok_reg;

    // Result register.
    logic                          out_valid_reg;
    logic [bctc_pkg::STATUS_W-1:0] status_reg;
    logic [bctc_pkg::STATUS_W-1:0] status_next;
    logic                          hit_reg;
    logic                          hit_next;
    bctc_pkg::entry_idx_t          idx_reg;
    bctc_pkg::entry_idx_t          idx_next;
    logic [bctc_pkg::SECTOR_W-1:0] first_reg;
    logic [bctc_pkg::SECTOR_W-1:0] first_next;

    // Datapath.
    logic                          advance;
    logic                          s1_load;
    logic [bctc_pkg::PROD_W-1:0]   first_prod;
    logic [bctc_pkg::PROD_W-1:0]   limit_prod;
    logic                          range_ok;
    bctc_pkg::valid_vec_t          valid_vec;
    bctc_pkg::tag_vec_t            tag_vec;
    bctc_pkg::entry_idx_t          ptr;
    bctc_pkg::lookup_t             look;
    bctc_pkg::update_t             upd;
    bctc_pkg::entry_idx_t          victim;

    // Handshake: the result register moves when empty or taken.
    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = s1_valid_reg && !advance;
    assign s1_load   = !in_stall;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign attach_clear = cfg_we && (cfg_index == bctc_pkg::CFG_DEVICE_ATTACHED)
                          && cfg_data[0];

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_sectors_reg <= '0;
            attached_reg    <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bctc_pkg::CFG_DEV_SECTORS:     dev_sectors_reg <= cfg_data;
                bctc_pkg::CFG_DEVICE_ATTACHED: attached_reg    <= cfg_data[0];
                default:                       ;
            endcase
        end
    end

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_load)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (s1_load && in_valid)
        begin
            s1_func_reg <= func;
            s1_blk_reg  <= block_number;
            s1_ok_reg   <= device_ok;
        end
    end

    // First sector and range check: block < sectors / spb  <=>  (block + 1) * spb <= sectors.
    assign first_prod = bctc_pkg::PROD_W'(s1_blk_reg)
                        * bctc_pkg::PROD_W'(bctc_pkg::SECTORS_PER_BLOCK);
    assign limit_prod = first_prod + bctc_pkg::PROD_W'(bctc_pkg::SECTORS_PER_BLOCK);
    assign range_ok   = attached_reg && (limit_prod <= bctc_pkg::PROD_W'(dev_sectors_reg));

    bctc_lookup u_lookup (
        .valid  (valid_vec),
        .tags   (tag_vec),
        .blk    (s1_blk_reg),
        .result (look)
    );

    bctc_tag_store u_tag_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .clear  (attach_clear),
        .upd    (upd),
        .blk    (s1_blk_reg),
        .valid  (valid_vec),
        .tags   (tag_vec),
        .ptr    (ptr)
    );

    // Victim: lowest free entry, else the round-robin entry.
    assign victim = look.free ? look.free_idx : ptr;

    // Request decision and state update.
    always_comb
    begin
        status_next = bctc_pkg::ST_OK;
        hit_next    = 1'b0;
        idx_next    = '0;
        first_next  = first_prod[bctc_pkg::SECTOR_W-1:0];
        upd         = '0;
        if (!range_ok)
        begin
            status_next = bctc_pkg::ST_REJECT;
            first_next  = '0;
        end
        else if (s1_func_reg == bctc_pkg::FUNC_READ)
        begin
            if (look.hit)
            begin
                hit_next = 1'b1;
                idx_next = look.hit_idx;
            end
            else
            begin
                idx_next      = victim;
                upd.idx       = victim;
                upd.adv_ptr   = !look.free;
                upd.set_valid = s1_ok_reg;
                upd.en        = 1'b1;
                if (!s1_ok_reg)
                begin
                    status_next = bctc_pkg::ST_DEV_ERR;
                end
            end
        end
        else if (!s1_ok_reg)
        begin
            // Failed write: no lookup reported, cache untouched.
            status_next = bctc_pkg::ST_DEV_ERR;
        end
        else
        begin
            upd.en        = 1'b1;
            upd.set_valid = 1'b1;
            if (look.hit)
            begin
                hit_next = 1'b1;
                idx_next = look.hit_idx;
                upd.idx  = look.hit_idx;
            end
            else
            begin
                idx_next    = victim;
                upd.idx     = victim;
                upd.adv_ptr = !look.free;
            end
        end
        // Only a request leaving the input register touches the state.
        if (!(s1_valid_reg && advance))
        begin
            upd = '0;
        end
    end

    // Result register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            status_reg <= status_next;
            hit_reg    <= hit_next;
            idx_reg    <= idx_next;
            first_reg  <= first_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign hit          = hit_reg;
    assign entry_index  = bctc_pkg::OUT_IDX_W'(idx_reg);
    assign start_sector = first_reg;

`ifndef SYNTHESIS
    // A rejected request reports nothing beyond its status.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (status_reg == bctc_pkg::ST_REJECT))
        |-> (!hit_reg && (idx_reg == '0) && (first_reg == '0)))
        else $error("rejected result carries lookup fields");

    // A hit is only ever reported with success.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && hit_reg) |-> (status_reg == bctc_pkg::ST_OK))
        else $error("hit reported with an error status");

    // A stalled result beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> (out_valid_reg && $stable(status_reg)
                                          && $stable(idx_reg) && $stable(first_reg)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

[test/testbench.sv]
// Self-checking testbench of the block cache tag controller with a scoreboard that predicts every result.
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 300000;
    localparam int POOL_SIZE   = 24;
    localparam logic [bctc_pkg::SECTOR_W-1:0] MAX_COUNT = {bctc_pkg::SECTOR_W{1'b1}};

    // Tracks the tag store and predicts the result beat of every accepted request.
    class cache_tag_predictor;
        typedef struct packed {
            logic [bctc_pkg::STATUS_W-1:0]  status;
            logic                           hit;
            logic [bctc_pkg::OUT_IDX_W-1:0] entry_index;
            logic [bctc_pkg::SECTOR_W-1:0]  start_sector;
        } outcome_t;

        logic [bctc_pkg::SECTOR_W-1:0] dev_sectors;
        logic                          attached;
        logic                          present[bctc_pkg::ENTRIES];
        bctc_pkg::tag_t                tags[bctc_pkg::ENTRIES];
        bctc_pkg::entry_idx_t          victim;
        outcome_t                      due_outcomes[$];
        int                            failures;
        int                            hits;
        int                            misses;
        int                            rejects;
        int                            dev_errors;
        int                            evictions;

        function new();
            dev_sectors = '0;
            attached    = 1'b0;
            victim      = '0;
            failures    = 0;
            hits        = 0;
            misses      = 0;
            rejects     = 0;
            dev_errors  = 0;
            evictions   = 0;
            foreach (present[i])
            begin
                present[i] = 1'b0;
                tags[i]    = '0;
            end
        endfunction

        function void note_config(logic [bctc_pkg::CFG_IDX_W-1:0] index,
                                  logic [bctc_pkg::CFG_DATA_W-1:0] data);
            if (index == bctc_pkg::CFG_DEV_SECTORS)
            begin
                dev_sectors = data;
            end
            else
            begin
                attached = data[0];
                // An attach empties the cache; a detach leaves the state alone.
                if (attached)
                begin
                    foreach (present[i])
                        present[i] = 1'b0;
                    victim = '0;
                end
            end
        endfunction

        function int match_entry(bctc_pkg::tag_t blk);
            for (int i = 0; i < bctc_pkg::ENTRIES; i++)
            begin
                if (present[i] && tags[i] == blk)
                    return i;
            end
            return -1;
        endfunction

        // Lowest free entry first, else the round-robin victim.
        function int pick_victim();
            int chosen;
            for (int i = 0; i < bctc_pkg::ENTRIES; i++)
            begin
                if (!present[i])
                    return i;
            end
            chosen = int'(victim);
            victim = victim + 1'b1;
            evictions++;
            return chosen;
        endfunction

        function void note_request(logic op, bctc_pkg::tag_t blk, logic ok);
            outcome_t                      res;
            logic [bctc_pkg::SECTOR_W-1:0] blocks;
            logic [bctc_pkg::SECTOR_W:0]   product;
            int                            idx;
            res     = '0;
            blocks  = dev_sectors / bctc_pkg::SECTORS_PER_BLOCK;
            product = blk * bctc_pkg::SECTORS_PER_BLOCK;
            if (!attached || dev_sectors < bctc_pkg::SECTORS_PER_BLOCK
                || {1'b0, blk} >= blocks)
            begin
                res.status = bctc_pkg::ST_REJECT;
                rejects++;
            end
            else
            begin
                res.start_sector = product[bctc_pkg::SECTOR_W-1:0];
                idx = match_entry(blk);
                if (op == bctc_pkg::FUNC_READ)
                begin
                    if (idx >= 0)
                    begin
                        res.hit = 1'b1;
                        hits++;
                    end
                    else
                    begin
                        idx = pick_victim();
                        misses++;
                        // A failed fill leaves the chosen entry empty.
                        if (!ok)
                        begin
                            present[idx] = 1'b0;
                            res.status   = bctc_pkg::ST_DEV_ERR;
                            dev_errors++;
                        end
                        else
                        begin
                            tags[idx]    = blk;
                            present[idx] = 1'b1;
                        end
                    end
                    res.entry_index = idx[bctc_pkg::OUT_IDX_W-1:0];
                end
                else if (!ok)
                begin
                    // A failed write touches nothing and reports no entry.
                    res.status = bctc_pkg::ST_DEV_ERR;
                    dev_errors++;
                end
                else
                begin
                    if (idx >= 0)
                    begin
                        res.hit = 1'b1;
                        hits++;
                    end
                    else
                    begin
                        idx = pick_victim();
                        misses++;
                    end
                    tags[idx]       = blk;
                    present[idx]    = 1'b1;
                    res.entry_index = idx[bctc_pkg::OUT_IDX_W-1:0];
                end
            end
            due_outcomes.push_back(res);
        endfunction

        function void check_result(logic [bctc_pkg::STATUS_W-1:0] st, logic h,
                                   logic [bctc_pkg::OUT_IDX_W-1:0] idx,
                                   logic [bctc_pkg::SECTOR_W-1:0] first);
            outcome_t want;
            if (due_outcomes.size() == 0)
            begin
                $error("result beat with no request outstanding");
                failures++;
                return;
            end
            want = due_outcomes.pop_front();
            if (st !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, st);
                failures++;
            end
            if (h !== want.hit)
            begin
                $error("hit: expected %0d, got %0d", want.hit, h);
                failures++;
            end
            if (idx !== want.entry_index)
            begin
                $error("entry_index: expected %0d, got %0d", want.entry_index, idx);
                failures++;
            end
            if (first !== want.start_sector)
            begin
                $error("start_sector: expected 0x%0h, got 0x%0h", want.start_sector, first);
                failures++;
            end
        endfunction
    endclass

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_stall;
    logic                            func;
    logic [bctc_pkg::TAG_W-1:0]      block_number;
    logic                            device_ok;
    logic                            out_valid;
    logic                            out_stall;
    logic [bctc_pkg::STATUS_W-1:0]   status;
    logic                            hit;
    logic [bctc_pkg::OUT_IDX_W-1:0]  entry_index;
    logic [bctc_pkg::SECTOR_W-1:0]   start_sector;
    logic                            cfg_valid;
    logic                            cfg_ready;
    logic [bctc_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [bctc_pkg::CFG_DATA_W-1:0] cfg_data;

    cache_tag_predictor              cache_model = new();
    bit                              quiet;
    int                              results_seen;
    int                              cycles;
    int                              settings_run;
    bctc_pkg::tag_t                  block_pool[POOL_SIZE];

    block_cache_tag_controller_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .block_number (block_number),
        .device_ok    (device_ok),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .hit          (hit),
        .entry_index  (entry_index),
        .start_sector (start_sector),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Clock with a period of 8 ns.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Run limit.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Result side: random stalls, plus long hold-offs that let the block fill up.
    always @(negedge clk)
    begin
        static int hold_left    = 0;
        static int next_hold_at = 150;
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else if (results_seen >= next_hold_at)
        begin
            out_stall <= 1'b1;
            hold_left = 60;
            next_hold_at += 450;
        end
        else
        begin
            out_stall <= !quiet && ($urandom_range(0, 99) < 13);
        end
    end

    // Every result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            cache_model.check_result(status, hit, entry_index, start_sector);
            results_seen++;
        end
    end

    // Offer one request beat and note it once it is accepted.
    task automatic send_request(logic op, bctc_pkg::tag_t blk, logic ok);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 13)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        func         <= op;
        block_number <= blk;
        device_ok    <= ok;
        do
            @(posedge clk);
        while (in_stall);
        cache_model.note_request(op, blk, ok);
    endtask

    task automatic drop_request();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every predicted result has arrived, then let the pipeline settle.
    task automatic wait_drained();
        while (cache_model.due_outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_register(logic [bctc_pkg::CFG_IDX_W-1:0] index,
                                  logic [bctc_pkg::CFG_DATA_W-1:0] data);
        wait_drained();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        cache_model.note_config(index, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // One setting of the device, then random requests drawn mostly from a small block pool,
    // so that hits, fills and round-robin evictions all happen.
    task automatic run_phase(logic [bctc_pkg::SECTOR_W-1:0] count, logic attach, int n,
                             bit calm);
        logic [bctc_pkg::SECTOR_W-1:0] blocks;
        longint unsigned               wide;
        bctc_pkg::tag_t                blk;
        int                            pick;
        write_register(bctc_pkg::CFG_DEV_SECTORS, count);
        write_register(bctc_pkg::CFG_DEVICE_ATTACHED,
                       {{(bctc_pkg::CFG_DATA_W-1){1'b0}}, attach});
        settings_run++;
        blocks = count / bctc_pkg::SECTORS_PER_BLOCK;
        foreach (block_pool[i])
        begin
            wide = {$urandom, $urandom};
            block_pool[i] = (blocks == 0) ? bctc_pkg::tag_t'($urandom)
                                          : bctc_pkg::tag_t'(wide % blocks);
        end
        quiet = calm;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 80)
            begin
                blk = block_pool[$urandom_range(0, POOL_SIZE - 1)];
            end
            else if (pick < 90)
            begin
                // Around the end of the device.
                case ($urandom_range(0, 2))
                    0:       blk = bctc_pkg::tag_t'(blocks - 1'b1);
                    1:       blk = bctc_pkg::tag_t'(blocks);
                    default: blk = '0;
                endcase
            end
            else
            begin
                blk = $urandom;
            end
            send_request(1'($urandom_range(0, 1)), blk, $urandom_range(0, 99) < 85);
            // The sender pauses once per setting until everything has come back.
            if (i == n / 2)
            begin
                drop_request();
                wait_drained();
            end
        end
        drop_request();
        quiet = 1'b0;
    endtask

    initial
    begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        func         = bctc_pkg::FUNC_READ;
        block_number = '0;
        device_ok    = 1'b0;
        out_stall    = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = bctc_pkg::CFG_DEV_SECTORS;
        cfg_data     = '0;
        quiet        = 1'b0;
        results_seen = 0;
        cycles       = 0;
        settings_run = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // No device after reset: everything is rejected.
        send_request(bctc_pkg::FUNC_READ, 32'd0, 1'b1);
        send_request(bctc_pkg::FUNC_WRITE, 32'hFFFF_FFFF, 1'b1);
        drop_request();

        // Attached, but the device is smaller than one block.
        write_register(bctc_pkg::CFG_DEV_SECTORS, 33'd1);
        write_register(bctc_pkg::CFG_DEVICE_ATTACHED, 33'd1);
        send_request(bctc_pkg::FUNC_READ, 32'd0, 1'b1);
        drop_request();

        // Largest device: fill, read hit ignoring the device, failed fill, failed write,
        // write miss, write hit, the last block and the first one past the end.
        write_register(bctc_pkg::CFG_DEV_SECTORS, MAX_COUNT);
        send_request(bctc_pkg::FUNC_READ, 32'd5, 1'b1);
        send_request(bctc_pkg::FUNC_READ, 32'd5, 1'b0);
        send_request(bctc_pkg::FUNC_READ, 32'd7, 1'b0);
        send_request(bctc_pkg::FUNC_WRITE, 32'd9, 1'b0);
        send_request(bctc_pkg::FUNC_WRITE, 32'd9, 1'b1);
        send_request(bctc_pkg::FUNC_WRITE, 32'd5, 1'b1);
        send_request(bctc_pkg::FUNC_READ, 32'hFFFF_FFFE, 1'b1);
        send_request(bctc_pkg::FUNC_READ, 32'hFFFF_FFFF, 1'b1);

        // Fill every entry, overflow into round-robin replacement, then a failed fill
        // on a full cache.
        for (int i = 0; i < 14; i++)
            send_request(bctc_pkg::FUNC_WRITE, 32'd100 + i, 1'b1);
        send_request(bctc_pkg::FUNC_READ, 32'd200, 1'b0);
        drop_request();

        // Random traffic over several device settings; the last one runs with no idling.
        run_phase(MAX_COUNT, 1'b1, 250, 1'b0);
        run_phase(33'd40, 1'b1, 200, 1'b0);
        run_phase({1'($urandom_range(0, 1)), 32'($urandom)}, 1'b1, 150, 1'b0);
        run_phase(33'd3, 1'b1, 80, 1'b0);
        run_phase(MAX_COUNT, 1'b0, 40, 1'b0);
        run_phase(33'd0, 1'b1, 40, 1'b0);
        run_phase(MAX_COUNT, 1'b1, 250, 1'b1);

        wait_drained();
        repeat (8) @(posedge clk);
        if (cache_model.due_outcomes.size() != 0)
        begin
            $error("%0d predicted results never arrived", cache_model.due_outcomes.size());
            cache_model.failures++;
        end

        $display("Checked %0d results over %0d device settings: %0d hits, %0d misses.",
                 results_seen, settings_run, cache_model.hits, cache_model.misses);
        $display("Rejected %0d, device errors %0d, round-robin evictions %0d.",
                 cache_model.rejects, cache_model.dev_errors, cache_model.evictions);
        if (cache_model.failures == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
